[sv/gcmc_pkg.sv]
package gcmc_pkg;

  // Fixed geometry of the beat formats.
  localparam int FINGERS       = 4;
  localparam int SAMPLE_BITS   = 16;
  localparam int TICK_BITS     = 32;
  localparam int LIMIT_BITS    = 16;
  localparam int TIMEOUT_BITS  = 32;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 3;
  localparam int SEL_BITS      = 2;

  // Squared magnitude widths: one square, a sum of three, the squared limit.
  localparam int SQ_BITS  = 2 * SAMPLE_BITS;
  localparam int MAG_BITS = SQ_BITS + 2;
  localparam int LSQ_BITS = 2 * LIMIT_BITS;
  localparam int CMP_BITS = (MAG_BITS > LSQ_BITS) ? MAG_BITS : LSQ_BITS;

  localparam logic [FINGERS-1:0]    RESET_MASK  = '1;
  localparam logic [LIMIT_BITS-1:0] RESET_LIMIT = LIMIT_BITS'(10);

  typedef enum logic [3:0] {
    FUNC_SAMPLE   = 4'd0,
    FUNC_TICK     = 4'd1,
    FUNC_GRASP    = 4'd2,
    FUNC_HOLD     = 4'd3,
    FUNC_OPEN     = 4'd4,
    FUNC_OPEN_LOG = 4'd5,
    FUNC_STEP     = 4'd6,
    FUNC_STOP     = 4'd7,
    FUNC_CLEAR    = 4'd8
  } func_t;

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_CLOSE     = 3'd1,
    MODE_HOLD      = 3'd2,
    MODE_OPEN      = 3'd3,
    MODE_OPEN_LOG  = 3'd4,
    MODE_STEP      = 3'd5,
    MODE_WAIT_OPEN = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_CLOSE = 3'd1,
    ACT_HOLD  = 3'd2,
    ACT_HOME  = 3'd3,
    ACT_STEP  = 3'd4,
    ACT_STOP  = 3'd5
  } act_t;

  typedef enum logic [1:0] {
    LOG_NONE  = 2'd0,
    LOG_START = 2'd1,
    LOG_STOP  = 2'd2
  } log_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MASK       = 3'd0,
    CFG_TOUCH      = 3'd1,
    CFG_GRASP_TO   = 3'd2,
    CFG_OPEN_TO    = 3'd3,
    CFG_LIM_THUMB  = 3'd4,
    CFG_LIM_INDEX  = 3'd5,
    CFG_LIM_MIDDLE = 3'd6,
    CFG_LIM_RING   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [3:0]                     func;
    logic [SEL_BITS-1:0]            finger_sel;
    logic signed [SAMPLE_BITS-1:0]  a_x;
    logic signed [SAMPLE_BITS-1:0]  a_y;
    logic signed [SAMPLE_BITS-1:0]  a_z;
    logic signed [SAMPLE_BITS-1:0]  b_x;
    logic signed [SAMPLE_BITS-1:0]  b_y;
    logic signed [SAMPLE_BITS-1:0]  b_z;
    logic                           encoders_ok;
  } in_t;

  typedef struct packed {
    logic [2:0]         mode_now;
    logic [2:0]         act_thumb;
    logic [2:0]         act_index;
    logic [2:0]         act_middle;
    logic [2:0]         act_ring;
    logic [FINGERS-1:0] contact_bits;
    logic [1:0]         logger_req;
  } out_t;

  typedef struct packed {
    logic [FINGERS-1:0]                 mask;
    logic                               use_touch;
    logic [TIMEOUT_BITS-1:0]            grasp_to;
    logic [TIMEOUT_BITS-1:0]            open_to;
    logic [FINGERS-1:0][LIMIT_BITS-1:0] limit;
  } cfg_t;

  // Beat as it enters the control stage: squares already formed.
  typedef struct packed {
    logic [3:0]                 func;
    logic [SEL_BITS-1:0]        sel;
    logic                       enc_ok;
    logic [2:0][SQ_BITS-1:0]    sq_a;
    logic [2:0][SQ_BITS-1:0]    sq_b;
    logic [LSQ_BITS-1:0]        lim_sq;
  } stage_t;

endpackage

[sv/gcmc_sq.sv]
module gcmc_sq (
  input  logic [2:0][gcmc_pkg::SAMPLE_BITS-1:0] axis_i,
  output logic [2:0][gcmc_pkg::SQ_BITS-1:0]     sq_o
);
  import gcmc_pkg::*;

  logic [2:0][SAMPLE_BITS-1:0] mag;

  // Absolute value fits in SAMPLE_BITS unsigned, including the most negative code.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i]  = axis_i[i][SAMPLE_BITS-1] ? (~axis_i[i] + SAMPLE_BITS'(1)) : axis_i[i];
      sq_o[i] = SQ_BITS'(mag[i]) * SQ_BITS'(mag[i]);
    end
  end

endmodule

[sv/gcmc_ctrl.sv]
module gcmc_ctrl #(
  parameter int TickBits = gcmc_pkg::TICK_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  gcmc_pkg::cfg_t   cfg_i,
  input  logic             fire_i,
  input  gcmc_pkg::stage_t item_i,
  output gcmc_pkg::out_t   res_o
);
  import gcmc_pkg::*;

  mode_t               mode_r, mode_nxt;
  logic [TickBits-1:0] elapsed_r, elapsed_nxt, elapsed_inc;
  logic [FINGERS-1:0]  latch_r, latch_nxt;
  logic [FINGERS-1:0]  over_r, over_nxt;
  logic                touch_r, touch_nxt;
  logic                enc_r, enc_nxt;

  logic [MAG_BITS-1:0] mag_a, mag_b;
  logic                over_hit;
  act_t                act [FINGERS];
  log_t                logger;

  // Contact test: sum of squares against the squared limit.
  always_comb begin
    mag_a = MAG_BITS'(item_i.sq_a[0]) + MAG_BITS'(item_i.sq_a[1]) +
            MAG_BITS'(item_i.sq_a[2]);
    mag_b = MAG_BITS'(item_i.sq_b[0]) + MAG_BITS'(item_i.sq_b[1]) +
            MAG_BITS'(item_i.sq_b[2]);
    over_hit = (CMP_BITS'(mag_a) >= CMP_BITS'(item_i.lim_sq)) ||
               (CMP_BITS'(mag_b) >= CMP_BITS'(item_i.lim_sq));
  end

  assign elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + TickBits'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      elapsed_r <= '0;
      latch_r   <= '0;
      over_r    <= '0;
      touch_r   <= 1'b0;
      enc_r     <= 1'b0;
    end else if (fire_i) begin
      mode_r    <= mode_nxt;
      elapsed_r <= elapsed_nxt;
      latch_r   <= latch_nxt;
      over_r    <= over_nxt;
      touch_r   <= touch_nxt;
      enc_r     <= enc_nxt;
    end
  end

  always_comb begin
    mode_nxt    = mode_r;
    elapsed_nxt = elapsed_r;
    latch_nxt   = latch_r;
    over_nxt    = over_r;
    touch_nxt   = touch_r;
    enc_nxt     = enc_r;
    logger      = LOG_NONE;
    for (int f = 0; f < FINGERS; f++) begin
      act[f] = ACT_NONE;
    end

    unique case (func_t'(item_i.func))
      FUNC_SAMPLE: begin
        touch_nxt = 1'b1;
        if (int'(item_i.sel) < FINGERS) begin
          over_nxt[item_i.sel] = over_hit;
        end
      end
      FUNC_TICK: begin
        if (item_i.enc_ok) begin
          enc_nxt = 1'b1;
        end
        if (!cfg_i.use_touch) begin
          touch_nxt = 1'b1;
        end
        unique case (mode_r)
          MODE_CLOSE: begin
            elapsed_nxt = elapsed_inc;
            if ((cfg_i.grasp_to != '0) &&
                (TIMEOUT_BITS'(elapsed_inc) > cfg_i.grasp_to)) begin
              mode_nxt = MODE_OPEN_LOG;
            end else if (touch_nxt && enc_nxt) begin
              for (int f = 0; f < FINGERS; f++) begin
                if (cfg_i.mask[f]) begin
                  if (!latch_r[f] && !over_r[f]) begin
                    act[f] = ACT_CLOSE;
                  end else begin
                    act[f]       = ACT_HOLD;
                    latch_nxt[f] = 1'b1;
                  end
                end
              end
            end
          end
          MODE_HOLD: begin
            for (int f = 0; f < FINGERS; f++) begin
              if (cfg_i.mask[f]) act[f] = ACT_HOLD;
            end
            mode_nxt = MODE_IDLE;
          end
          MODE_OPEN: begin
            for (int f = 0; f < FINGERS; f++) begin
              if (cfg_i.mask[f]) act[f] = ACT_HOME;
            end
            mode_nxt = MODE_IDLE;
          end
          MODE_OPEN_LOG: begin
            for (int f = 0; f < FINGERS; f++) begin
              if (cfg_i.mask[f]) act[f] = ACT_HOME;
            end
            if (cfg_i.open_to != '0) begin
              mode_nxt    = MODE_WAIT_OPEN;
              elapsed_nxt = '0;
            end else begin
              mode_nxt = MODE_IDLE;
            end
          end
          MODE_STEP: begin
            if (enc_nxt) begin
              for (int f = 0; f < FINGERS; f++) begin
                if (cfg_i.mask[f]) act[f] = ACT_STEP;
              end
            end
            mode_nxt = MODE_IDLE;
          end
          MODE_WAIT_OPEN: begin
            elapsed_nxt = elapsed_inc;
            if (TIMEOUT_BITS'(elapsed_inc) > cfg_i.open_to) begin
              logger   = LOG_STOP;
              mode_nxt = MODE_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
      FUNC_GRASP: begin
        logger      = LOG_START;
        mode_nxt    = MODE_CLOSE;
        latch_nxt   = '0;
        elapsed_nxt = '0;
      end
      FUNC_HOLD:     mode_nxt = MODE_HOLD;
      FUNC_OPEN:     mode_nxt = MODE_OPEN;
      FUNC_OPEN_LOG: mode_nxt = MODE_OPEN_LOG;
      FUNC_STEP:     mode_nxt = MODE_STEP;
      FUNC_STOP: begin
        mode_nxt = MODE_IDLE;
        for (int f = 0; f < FINGERS; f++) begin
          if (cfg_i.mask[f]) act[f] = ACT_STOP;
        end
      end
      FUNC_CLEAR:    latch_nxt = '0;
      default: begin
      end
    endcase

    res_o.mode_now     = mode_nxt;
    res_o.act_thumb    = act[0];
    res_o.act_index    = act[1];
    res_o.act_middle   = act[2];
    res_o.act_ring     = act[3];
    res_o.contact_bits = latch_nxt;
    res_o.logger_req   = logger;
  end

endmodule

[sv/grasp_contact_mode_controller_core.sv]
// Grasp mode controller for four fingers. Every input beat (tactile sample,
// control tick or command) yields exactly one result beat, and a new beat is
// taken in every cycle in which in_ready is high. The path has three
// registered stages: an input register, a stage holding the six axis squares
// and the squared limit of the selected finger, and the output register. The
// mode, tick counter, contact latches and per-finger over-limit flags update
// in the second stage, so each beat sees the state left by the one before it.
// in_ready falls only when all three stages hold beats and the output is
// stalled. Configuration writes take effect on the next edge and must be
// issued with no beat in flight.
module grasp_contact_mode_controller_core #(
  parameter int TickBits = gcmc_pkg::TICK_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  gcmc_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gcmc_pkg::out_t                      out_data,
  input  logic                                cfg_we,
  input  logic [gcmc_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
  input  logic [gcmc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import gcmc_pkg::*;

  cfg_t   cfg_r;

  // Input register.
  logic   a_v_r;
  in_t    a_r;
  logic   a_ready;

  // Square stage.
  logic   b_v_r;
  stage_t b_r, b_nxt;
  logic   b_ready, b_fire;

  // Output register.
  logic   out_v_r;
  out_t   out_r;
  logic   o_ready;
  out_t   res;

  logic [LIMIT_BITS-1:0] lim_sel;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mask      <= RESET_MASK;
      cfg_r.use_touch <= 1'b0;
      cfg_r.grasp_to  <= '0;
      cfg_r.open_to   <= '0;
      for (int f = 0; f < FINGERS; f++) begin
        cfg_r.limit[f] <= RESET_LIMIT;
      end
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_MASK:       cfg_r.mask      <= cfg_wdata[FINGERS-1:0];
        CFG_TOUCH:      cfg_r.use_touch <= cfg_wdata[0];
        CFG_GRASP_TO:   cfg_r.grasp_to  <= cfg_wdata[TIMEOUT_BITS-1:0];
        CFG_OPEN_TO:    cfg_r.open_to   <= cfg_wdata[TIMEOUT_BITS-1:0];
        CFG_LIM_THUMB:  cfg_r.limit[0]  <= cfg_wdata[LIMIT_BITS-1:0];
        CFG_LIM_INDEX:  cfg_r.limit[1]  <= cfg_wdata[LIMIT_BITS-1:0];
        CFG_LIM_MIDDLE: cfg_r.limit[2]  <= cfg_wdata[LIMIT_BITS-1:0];
        CFG_LIM_RING:   cfg_r.limit[3]  <= cfg_wdata[LIMIT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Each stage moves when it is empty or the stage after it moves.
  assign o_ready  = !out_v_r || out_ready;
  assign b_ready  = !b_v_r || o_ready;
  assign b_fire   = b_v_r && o_ready;
  assign a_ready  = !a_v_r || b_ready;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_ready) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_r <= in_data;
    end
  end

  // Squares of both sensors and of the selected finger's limit.
  gcmc_sq u_sq_a (
    .axis_i ({a_r.a_z, a_r.a_y, a_r.a_x}),
    .sq_o   (b_nxt.sq_a)
  );

  gcmc_sq u_sq_b (
    .axis_i ({a_r.b_z, a_r.b_y, a_r.b_x}),
    .sq_o   (b_nxt.sq_b)
  );

  assign lim_sel      = cfg_r.limit[a_r.finger_sel];
  assign b_nxt.lim_sq = LSQ_BITS'(lim_sel) * LSQ_BITS'(lim_sel);
  assign b_nxt.func   = a_r.func;
  assign b_nxt.sel    = a_r.finger_sel;
  assign b_nxt.enc_ok = a_r.encoders_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_ready) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_v_r) begin
      b_r <= b_nxt;
    end
  end

  // Mode sequencing and contact latching; state commits as the beat leaves.
  gcmc_ctrl #(
    .TickBits (TickBits)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_i  (cfg_r),
    .fire_i (b_fire),
    .item_i (b_r),
    .res_o  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (o_ready) begin
      out_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      out_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

[sv/gcmc_chk.sv]
module gcmc_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input gcmc_pkg::out_t out_data
);
  import gcmc_pkg::*;

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Input back-pressure only comes from a waiting result.
  a_ready_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with free pipeline space");

  // A logging start only comes with a grasp: close mode, latches cleared.
  a_grasp_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.logger_req == LOG_START |->
      out_data.mode_now == MODE_CLOSE && out_data.contact_bits == '0)
    else $error("logging start outside a grasp command");

  // A finger driven to close is in close mode and not latched.
  a_close_unlatched: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.act_thumb == ACT_CLOSE || out_data.act_index == ACT_CLOSE ||
                  out_data.act_middle == ACT_CLOSE || out_data.act_ring == ACT_CLOSE) |->
      out_data.mode_now == MODE_CLOSE &&
      !(out_data.act_thumb == ACT_CLOSE && out_data.contact_bits[0]) &&
      !(out_data.act_index == ACT_CLOSE && out_data.contact_bits[1]) &&
      !(out_data.act_middle == ACT_CLOSE && out_data.contact_bits[2]) &&
      !(out_data.act_ring == ACT_CLOSE && out_data.contact_bits[3]))
    else $error("close action on a latched finger or outside close mode");

endmodule

bind grasp_contact_mode_controller_core gcmc_chk u_gcmc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
